FILE: rtl/fdds_pkg.sv
// Shared types and constants for the four-digit display scanner.
// No dependencies; used by fdds_decimal and four_digit_display_scanner.
package fdds_pkg;

  localparam logic [3:0] BLANK_CODE  = 4'd15;
  localparam int         DIGIT_COUNT = 4;

  // Operation codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_PUT16 = 3'd2;
  localparam logic [2:0] OP_PUT8  = 3'd3;
  localparam logic [2:0] OP_LED   = 3'd4;

  // LED commands
  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_ON     = 2'd1;
  localparam logic [1:0] LED_TOGGLE = 2'd2;
  localparam logic [1:0] LED_KEEP   = 2'd3;

  // Position select codes beyond the digits
  localparam logic [2:0] POS_LED  = 3'd4;
  localparam logic [2:0] POS_IDLE = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  digit_index;
    logic [3:0]  digit_value;
    logic [15:0] number_in;
    logic        low_pair_select;
    logic [1:0]  led_command;
  } in_item_t;

  typedef struct packed {
    logic [3:0] segment_code;
    logic [2:0] position_select;
  } out_item_t;

  // Decimal digits of a request's number: four from the 16-bit value,
  // units and tens of the low byte.
  typedef struct packed {
    logic [3:0][3:0] dec16;
    logic [1:0][3:0] dec8;
  } dec_digits_t;

endpackage

FILE: rtl/fdds_decimal.sv
// Decimal split of a 16-bit number and of its low byte.
// Registered reciprocal multiplies, then digit extraction; uses fdds_pkg.
module fdds_decimal (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          number,
  output fdds_pkg::dec_digits_t digits
);

  logic [15:0] num_r;
  logic [12:0] q10_r;
  logic [9:0]  q100_r;
  logic [6:0]  q1000_r;
  logic [4:0]  b10_r;

  logic [31:0] p10;
  logic [32:0] p100;
  logic [32:0] p1000;
  logic [15:0] pb10;

  // Reciprocals are exact over the full 16-bit (or 8-bit) input range.
  assign p10   = 32'(number) * 32'd52429;
  assign p100  = 33'(number) * 33'd83887;
  assign p1000 = 33'(number) * 33'd67109;
  assign pb10  = 16'(number[7:0]) * 16'd205;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= number;
      q10_r   <= p10[31:19];
      q100_r  <= p100[32:23];
      q1000_r <= p1000[32:26];
      b10_r   <= pb10[15:11];
    end
  end

  // Remainder mod 10 of a value below 70
  function automatic logic [3:0] mod10_small(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    for (int k = 1; k <= 6; k++) begin
      if (v >= 7'(10 * k)) r = v - 7'(10 * k);
    end
    return r[3:0];
  endfunction

  logic [15:0] r0;
  logic [12:0] r1;
  logic [9:0]  r2;
  logic [7:0]  rb0;

  assign r0  = num_r - (16'({q10_r, 3'b000}) + 16'({q10_r, 1'b0}));
  assign r1  = q10_r - (13'({q100_r, 3'b000}) + 13'({q100_r, 1'b0}));
  assign r2  = q100_r - (10'({q1000_r, 3'b000}) + 10'({q1000_r, 1'b0}));
  assign rb0 = num_r[7:0] - (8'({b10_r, 3'b000}) + 8'({b10_r, 1'b0}));

  always_comb begin
    digits.dec16[0] = r0[3:0];
    digits.dec16[1] = r1[3:0];
    digits.dec16[2] = r2[3:0];
    digits.dec16[3] = mod10_small(q1000_r);
    digits.dec8[0]  = rb0[3:0];
    digits.dec8[1]  = mod10_small({2'b00, b10_r});
  end

endmodule

FILE: rtl/four_digit_display_scanner.sv
// Top level of the four-digit multiplexed display scanner.
// Uses fdds_pkg and fdds_decimal.

// Requests pass through three registers: input, decimal split, and the
// execute step that updates the digit store, LED flag and scan position.
// One request is taken every cycle unless a tick waits on a held output;
// a tick's result passes the input, split and output registers in turn,
// and requests are handled strictly in order. Number writes use the decimal
// split (registered reciprocal multiplies, then digit extraction). A waiting
// result holds only a tick behind it; others keep flowing until the pipe fills.
// After reset every digit is blank, the LED is off and the scan is at digit 0.
module four_digit_display_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdds_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fdds_pkg::out_item_t out_data
);

  logic                s1_v_r, s1_v_nxt;
  fdds_pkg::in_item_t  s1_r;
  logic                s2_v_r, s2_v_nxt;
  fdds_pkg::in_item_t  s2_r;
  logic                out_valid_r, out_valid_nxt;
  fdds_pkg::out_item_t out_r, out_nxt;

  logic [3:0][3:0] digit_r, digit_nxt;
  logic            led_r, led_nxt;
  logic [2:0]      scan_r, scan_nxt;

  logic s2_tick, out_can, s2_fire, s2_free, s2_load, in_accept;
  fdds_pkg::dec_digits_t dec;

  fdds_decimal u_dec (
    .clk    (clk),
    .en     (s2_load),
    .number (s1_r.number_in),
    .digits (dec)
  );

  assign s2_tick   = (s2_r.opcode == fdds_pkg::OP_TICK);
  assign out_can   = !out_valid_r || out_ready;
  assign s2_fire   = s2_v_r && (!s2_tick || out_can);
  assign s2_free   = !s2_v_r || s2_fire;
  assign s2_load   = s1_v_r && s2_free;
  assign in_ready  = !s1_v_r || s2_free;
  assign in_accept = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) s1_v_nxt = 1'b1;
    else if (s2_free) s1_v_nxt = 1'b0;
    s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
    out_valid_nxt = out_valid_r;
    if (s2_fire && s2_tick) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // Execute step
  always_comb begin
    digit_nxt = digit_r;
    led_nxt   = led_r;
    scan_nxt  = scan_r;
    out_nxt   = out_r;
    if (s2_fire) begin
      case (s2_r.opcode)
        fdds_pkg::OP_TICK: begin
          if (32'(scan_r) >= fdds_pkg::DIGIT_COUNT) begin
            out_nxt.segment_code    = 4'd0;
            out_nxt.position_select = led_r ? fdds_pkg::POS_LED : fdds_pkg::POS_IDLE;
            scan_nxt = 3'd0;
          end else begin
            out_nxt.segment_code    = digit_r[scan_r[1:0]];
            out_nxt.position_select = scan_r;
            scan_nxt = scan_r + 3'd1;
          end
        end
        fdds_pkg::OP_SET: begin
          digit_nxt[s2_r.digit_index] = s2_r.digit_value;
        end
        fdds_pkg::OP_PUT16: begin
          digit_nxt = dec.dec16;
        end
        fdds_pkg::OP_PUT8: begin
          if (s2_r.low_pair_select) begin
            digit_nxt[0] = dec.dec8[0];
            digit_nxt[1] = dec.dec8[1];
          end else begin
            digit_nxt[2] = dec.dec8[0];
            digit_nxt[3] = dec.dec8[1];
          end
        end
        fdds_pkg::OP_LED: begin
          case (s2_r.led_command)
            fdds_pkg::LED_OFF:    led_nxt = 1'b0;
            fdds_pkg::LED_ON:     led_nxt = 1'b1;
            fdds_pkg::LED_TOGGLE: led_nxt = !led_r;
            default:              led_nxt = led_r;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      digit_r     <= {4{fdds_pkg::BLANK_CODE}};
      led_r       <= 1'b0;
      scan_r      <= 3'd0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
      digit_r     <= digit_nxt;
      led_r       <= led_nxt;
      scan_r      <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_r <= in_data;
    if (s2_load) s2_r <= s1_r;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.position_select <= fdds_pkg::POS_IDLE))
    else $error("position select out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.position_select >= fdds_pkg::POS_LED))
      |-> (out_r.segment_code == 4'd0))
    else $error("LED or idle slot carries a digit code");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_r) <= fdds_pkg::DIGIT_COUNT)
    else $error("scan position past end of scan");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && s2_tick && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipe is blocked");

  a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && (s2_r.opcode == fdds_pkg::OP_LED)
      && (s2_r.led_command == fdds_pkg::LED_TOGGLE)) |=> (led_r != $past(led_r)))
    else $error("LED toggle did not invert the flag");
`endif

endmodule
